### sv/vcpz_pkg.sv
// ----------------------------------------------------------------------------
// vcpz_pkg: shared definitions for the view camera pan/zoom block
// Command codes, register indexes, datapath micro-operations, the controller
// micro-sequence and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package vcpz_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int ZOOM_FRAC_BITS_DEF  = 16;

   localparam int DIV_N_W = 64;   // dividend magnitude width
   localparam int DIV_D_W = 32;   // divisor width (zoom or box extent)
   localparam int PC_W    = 4;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 32;

   typedef logic [2:0] cmd_type;
   localparam cmd_type CMD_W2S     = 3'd0;
   localparam cmd_type CMD_S2W     = 3'd1;
   localparam cmd_type CMD_PAN     = 3'd2;
   localparam cmd_type CMD_ZOOM_AT = 3'd3;
   localparam cmd_type CMD_FRAME   = 3'd4;
   localparam cmd_type CMD_SET     = 3'd5;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_VP_W  = 8'd0;
   localparam csr_idx_type REG_VP_H  = 8'd1;
   localparam csr_idx_type REG_MIN_Z = 8'd2;
   localparam csr_idx_type REG_MAX_Z = 8'd3;

   typedef logic [4:0] op_type;
   localparam op_type OP_NOP     = 5'd0;
   localparam op_type OP_IGN     = 5'd1;
   localparam op_type OP_MULS_PT = 5'd2;
   localparam op_type OP_MULS_O  = 5'd3;
   localparam op_type OP_FINS    = 5'd4;
   localparam op_type OP_DIVW    = 5'd5;
   localparam op_type OP_FINW    = 5'd6;
   localparam op_type OP_DIVP    = 5'd7;
   localparam op_type OP_FINP    = 5'd8;
   localparam op_type OP_DIVA    = 5'd9;
   localparam op_type OP_FINA    = 5'd10;
   localparam op_type OP_ZMUL    = 5'd11;
   localparam op_type OP_ZSETP   = 5'd12;
   localparam op_type OP_ZSETA   = 5'd13;
   localparam op_type OP_FRAMEC  = 5'd14;
   localparam op_type OP_FMUL    = 5'd15;
   localparam op_type OP_DIVF    = 5'd16;
   localparam op_type OP_FINF    = 5'd17;
   localparam op_type OP_ZSETF   = 5'd18;

   typedef struct packed {
      op_type op;
      logic   axis;    // 0 x, 1 y
      logic   last;
   } uop_type;

   typedef struct packed {
      logic   load;
      logic   issue;
      op_type op;
      logic   axis;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic short_path;
   } dp_sts_type;

   function automatic logic is_div_op(input op_type op);
      return (op == OP_DIVW) || (op == OP_DIVP) || (op == OP_DIVA) || (op == OP_DIVF);
   endfunction

   function automatic uop_type mk(input op_type op, input logic axis, input logic last);
      uop_type u;
      u.op   = op;
      u.axis = axis;
      u.last = last;
      return u;
   endfunction

   // Micro-sequence of each command; short_path selects the rejected zoom or
   // the centre-only frame.
   function automatic uop_type ucode(input cmd_type cmd, input logic [PC_W-1:0] pc,
                                     input logic short_path);
      uop_type u;
      u = mk(OP_IGN, 1'b0, 1'b1);
      unique case (cmd)
         CMD_W2S: begin
            unique case (pc)
               4'd0: u = mk(OP_MULS_PT, 1'b0, 1'b0);
               4'd1: u = mk(OP_FINS, 1'b0, 1'b0);
               4'd2: u = mk(OP_MULS_PT, 1'b1, 1'b0);
               default: u = mk(OP_FINS, 1'b1, 1'b1);
            endcase
         end
         CMD_S2W: begin
            unique case (pc)
               4'd0: u = mk(OP_DIVW, 1'b0, 1'b0);
               4'd1: u = mk(OP_FINW, 1'b0, 1'b0);
               4'd2: u = mk(OP_DIVW, 1'b1, 1'b0);
               default: u = mk(OP_FINW, 1'b1, 1'b1);
            endcase
         end
         CMD_PAN: begin
            unique case (pc)
               4'd0: u = mk(OP_DIVP, 1'b0, 1'b0);
               4'd1: u = mk(OP_FINP, 1'b0, 1'b0);
               4'd2: u = mk(OP_DIVP, 1'b1, 1'b0);
               default: u = mk(OP_FINP, 1'b1, 1'b1);
            endcase
         end
         CMD_ZOOM_AT: begin
            if (short_path) begin
               u = mk(OP_IGN, 1'b0, 1'b1);
            end else begin
               unique case (pc)
                  4'd0:  u = mk(OP_DIVW, 1'b0, 1'b0);
                  4'd1:  u = mk(OP_FINW, 1'b0, 1'b0);
                  4'd2:  u = mk(OP_DIVW, 1'b1, 1'b0);
                  4'd3:  u = mk(OP_FINW, 1'b1, 1'b0);
                  4'd4:  u = mk(OP_ZMUL, 1'b0, 1'b0);
                  4'd5:  u = mk(OP_ZSETP, 1'b0, 1'b0);
                  4'd6:  u = mk(OP_MULS_O, 1'b0, 1'b0);
                  4'd7:  u = mk(OP_FINS, 1'b0, 1'b0);
                  4'd8:  u = mk(OP_MULS_O, 1'b1, 1'b0);
                  4'd9:  u = mk(OP_FINS, 1'b1, 1'b0);
                  4'd10: u = mk(OP_DIVA, 1'b0, 1'b0);
                  4'd11: u = mk(OP_FINA, 1'b0, 1'b0);
                  4'd12: u = mk(OP_DIVA, 1'b1, 1'b0);
                  default: u = mk(OP_FINA, 1'b1, 1'b1);
               endcase
            end
         end
         CMD_FRAME: begin
            unique case (pc)
               4'd0: u = mk(OP_FRAMEC, 1'b0, short_path);
               4'd1: u = mk(OP_FMUL, 1'b0, 1'b0);
               4'd2: u = mk(OP_DIVF, 1'b0, 1'b0);
               4'd3: u = mk(OP_FINF, 1'b0, 1'b0);
               4'd4: u = mk(OP_FMUL, 1'b1, 1'b0);
               4'd5: u = mk(OP_DIVF, 1'b1, 1'b0);
               4'd6: u = mk(OP_FINF, 1'b1, 1'b0);
               default: u = mk(OP_ZSETF, 1'b0, 1'b1);
            endcase
         end
         CMD_SET: u = mk(OP_ZSETA, 1'b0, 1'b1);
         default: u = mk(OP_IGN, 1'b0, 1'b1);
      endcase
      return u;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [23:0] clamp_zoom(input logic [63:0] z, input logic [23:0] mn,
                                              input logic [23:0] mx);
      logic [23:0] lo;
      logic [23:0] hi;
      logic [23:0] r;
      lo = (mn != 24'd0) ? mn : 24'd1;
      hi = (mx < lo) ? lo : mx;
      if (z < {40'd0, lo}) begin
         r = lo;
      end else if (z > {40'd0, hi}) begin
         r = hi;
      end else begin
         r = z[23:0];
      end
      return r;
   endfunction

endpackage

### sv/vcpz_div.sv
// ----------------------------------------------------------------------------
// vcpz_div: serial unsigned divider with round-to-nearest
// Restoring division, one quotient bit per cycle; returns (a + d/2) / d.
// ----------------------------------------------------------------------------
module vcpz_div #(
   parameter int NW = vcpz_pkg::DIV_N_W,
   parameter int DW = vcpz_pkg::DIV_D_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [NW-1:0] quotient,
   output logic          done
);

   localparam int CW = $clog2(NW);

   logic          running_ff, running_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;

   always_comb begin
      running_in = running_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      den_in     = den_ff;
      trial      = {rem_ff, quo_ff[NW-1]};
      if (start) begin
         running_in = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = dividend + NW'(divisor >> 1);
         den_in     = divisor;
      end else if (running_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            running_in = 1'b0;
            done_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         running_ff <= running_in;
         done_ff    <= done_in;
         cnt_ff     <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

### sv/vcpz_dp.sv
// ----------------------------------------------------------------------------
// vcpz_dp: camera datapath
// Camera state, configuration registers, request latches, three multipliers and
// the shared serial divider, driven one micro-operation at a time.
// ----------------------------------------------------------------------------
module vcpz_dp #(
   parameter int COORD_FRAC_BITS = vcpz_pkg::COORD_FRAC_BITS_DEF,
   parameter int ZOOM_FRAC_BITS  = vcpz_pkg::ZOOM_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vcpz_pkg::dp_cmd_type          ctl,
   output vcpz_pkg::dp_sts_type          sts,
   input  vcpz_pkg::cmd_type             req_command,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_corner_x,
   input  logic signed [31:0]            req_corner_y,
   input  logic [23:0]                   req_amount,
   input  logic                          csr_wr,
   input  vcpz_pkg::csr_idx_type         csr_index,
   input  logic [vcpz_pkg::CSR_DAT_W-1:0] csr_data,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_center_x,
   output logic signed [31:0]            rsp_center_y,
   output logic [23:0]                   rsp_zoom_level,
   output logic                          rsp_ignored
);

   localparam int ZF = ZOOM_FRAC_BITS;
   localparam int CF = COORD_FRAC_BITS;
   localparam logic [ZF:0] ONE = (ZF+1)'(1) << ZF;
   localparam logic [ZF:0] CAP = (ZF+1)'((45 * (64'd1 << ZF) + 50) / 100);
   localparam logic signed [63:0] HALF_Z = 64'sd1 <<< (ZF - 1);
   localparam logic [63:0] HALF_ZU = 64'd1 << (ZF - 1);

   // configuration
   logic [15:0] vp_w_ff, vp_w_in, vp_h_ff, vp_h_in;
   logic [23:0] min_z_ff, min_z_in, max_z_ff, max_z_in;
   // camera
   logic [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [23:0] zoom_ff, zoom_in;
   // request latches
   vcpz_pkg::cmd_type cmd_ff;
   logic [31:0] px_ff, py_ff, qx_ff, qy_ff;
   logic [23:0] amt_ff;
   // work registers
   logic [31:0] ox_ff, ox_in, oy_ff, oy_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] fit_ff, fit_in;
   logic        ign_ff, ign_in;
   logic        neg_ff, neg_in;

   logic [31:0] p_a, q_a, c_a, o_a;
   logic [15:0] size_a;
   logic signed [63:0] p64, q64, c64, o64, hs64, n64, qs64, sum64;
   logic signed [32:0] diff33;
   logic signed [57:0] mres;
   logic [47:0] zprod;
   logic [16+ZF:0] fprod;
   logic [23:0] m;
   logic [ZF:0] usable;
   logic        degen, vp_zero;
   logic        div_start;
   logic [63:0] div_a, div_q;
   logic [31:0] div_d;
   logic        div_done;

   assign p_a    = ctl.axis ? py_ff : px_ff;
   assign q_a    = ctl.axis ? qy_ff : qx_ff;
   assign c_a    = ctl.axis ? cy_ff : cx_ff;
   assign o_a    = ctl.axis ? oy_ff : ox_ff;
   assign size_a = ctl.axis ? vp_h_ff : vp_w_ff;
   assign p64    = {{32{p_a[31]}}, p_a};
   assign q64    = {{32{q_a[31]}}, q_a};
   assign c64    = {{32{c_a[31]}}, c_a};
   assign o64    = {{32{o_a[31]}}, o_a};
   assign hs64   = $signed(64'(size_a) << (CF - 1));
   assign qs64   = neg_ff ? -$signed(div_q) : $signed(div_q);
   assign degen  = ($signed(qx_ff) <= $signed(px_ff)) || ($signed(qy_ff) <= $signed(py_ff));
   assign vp_zero = (vp_w_ff == 16'd0) || (vp_h_ff == 16'd0);
   assign m      = ({{(24-ZF-1){1'b0}}, CAP} > amt_ff) ? amt_ff : 24'(CAP);
   assign usable = ONE - (ZF+1)'({m, 1'b0});
   // Full-width products of the zoom update and of the frame fit.
   assign zprod  = zoom_ff * amt_ff;
   assign fprod  = size_a * usable;

   always_comb begin
      vp_w_in  = vp_w_ff;
      vp_h_in  = vp_h_ff;
      min_z_in = min_z_ff;
      max_z_in = max_z_ff;
      if (csr_wr) begin
         unique case (csr_index)
            vcpz_pkg::REG_VP_W:  vp_w_in  = csr_data[15:0];
            vcpz_pkg::REG_VP_H:  vp_h_in  = csr_data[15:0];
            vcpz_pkg::REG_MIN_Z: min_z_in = csr_data[23:0];
            vcpz_pkg::REG_MAX_Z: max_z_in = csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      zoom_in   = zoom_ff;
      ox_in     = ox_ff;
      oy_in     = oy_ff;
      prod_in   = prod_ff;
      fit_in    = fit_ff;
      ign_in    = ign_ff;
      neg_in    = neg_ff;
      div_start = 1'b0;
      div_d     = {8'd0, zoom_ff};
      n64       = '0;
      sum64     = '0;
      diff33    = '0;
      mres      = '0;
      if (ctl.load) begin
         ign_in = 1'b0;
         ox_in  = '0;
         oy_in  = '0;
      end else if (ctl.issue) begin
         unique case (ctl.op)
            vcpz_pkg::OP_IGN: ign_in = 1'b1;
            vcpz_pkg::OP_MULS_PT, vcpz_pkg::OP_MULS_O: begin
               diff33 = (ctl.op == vcpz_pkg::OP_MULS_PT) ? 33'(p64 - c64) : 33'(o64 - c64);
               mres = diff33 * $signed({1'b0, zoom_ff});
               prod_in = {{6{mres[57]}}, mres};
            end
            vcpz_pkg::OP_FINS: begin
               sum64 = ((prod_ff + HALF_Z) >>> ZF) + hs64;
               if (ctl.axis) oy_in = vcpz_pkg::sat32(sum64);
               else          ox_in = vcpz_pkg::sat32(sum64);
            end
            vcpz_pkg::OP_DIVW, vcpz_pkg::OP_DIVP, vcpz_pkg::OP_DIVA: begin
               unique case (ctl.op)
                  vcpz_pkg::OP_DIVW: n64 = (p64 - hs64) <<< ZF;
                  vcpz_pkg::OP_DIVP: n64 = p64 <<< ZF;
                  default:           n64 = (o64 - p64) <<< ZF;
               endcase
               neg_in    = n64[63];
               div_start = 1'b1;
            end
            vcpz_pkg::OP_FINW: begin
               sum64 = qs64 + c64;
               if (ctl.axis) oy_in = vcpz_pkg::sat32(sum64);
               else          ox_in = vcpz_pkg::sat32(sum64);
            end
            vcpz_pkg::OP_FINP, vcpz_pkg::OP_FINA: begin
               sum64 = (ctl.op == vcpz_pkg::OP_FINP) ? (c64 - qs64) : (c64 + qs64);
               if (ctl.axis) cy_in = vcpz_pkg::sat32(sum64);
               else          cx_in = vcpz_pkg::sat32(sum64);
            end
            vcpz_pkg::OP_ZMUL: prod_in = $signed(64'(zprod) + HALF_ZU);
            vcpz_pkg::OP_ZSETP:
               zoom_in = vcpz_pkg::clamp_zoom(64'($unsigned(prod_ff)) >> ZF, min_z_ff, max_z_ff);
            vcpz_pkg::OP_ZSETA: zoom_in = vcpz_pkg::clamp_zoom(64'(amt_ff), min_z_ff, max_z_ff);
            vcpz_pkg::OP_FRAMEC: begin
               if (degen) begin
                  cx_in = px_ff;
                  cy_in = py_ff;
               end else begin
                  cx_in = 32'(({{32{px_ff[31]}}, px_ff} + {{32{qx_ff[31]}}, qx_ff}) >>> 1);
                  cy_in = 32'(({{32{py_ff[31]}}, py_ff} + {{32{qy_ff[31]}}, qy_ff}) >>> 1);
               end
            end
            vcpz_pkg::OP_FMUL: prod_in = $signed(64'(fprod));
            vcpz_pkg::OP_DIVF: begin
               n64       = prod_ff <<< CF;
               neg_in    = 1'b0;
               div_d     = 32'(q64 - p64);
               div_start = 1'b1;
            end
            vcpz_pkg::OP_FINF: begin
               if (!ctl.axis || (div_q < fit_ff)) fit_in = div_q;
            end
            vcpz_pkg::OP_ZSETF: zoom_in = vcpz_pkg::clamp_zoom(fit_ff, min_z_ff, max_z_ff);
            default: ;
         endcase
      end
   end

   assign div_a = n64[63] ? $unsigned(-n64) : $unsigned(n64);

   vcpz_div #(
      .NW(vcpz_pkg::DIV_N_W),
      .DW(vcpz_pkg::DIV_D_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_a),
      .divisor  (div_d),
      .quotient (div_q),
      .done     (div_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_w_ff  <= 16'd1280;
         vp_h_ff  <= 16'd720;
         min_z_ff <= 24'd6554;
         max_z_ff <= 24'd1048576;
         cx_ff    <= '0;
         cy_ff    <= '0;
         zoom_ff  <= 24'(ONE);
         ign_ff   <= 1'b0;
      end else begin
         vp_w_ff  <= vp_w_in;
         vp_h_ff  <= vp_h_in;
         min_z_ff <= min_z_in;
         max_z_ff <= max_z_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         zoom_ff  <= zoom_in;
         ign_ff   <= ign_in;
      end
      if (ctl.load) begin
         cmd_ff <= req_command;
         px_ff  <= req_point_x;
         py_ff  <= req_point_y;
         qx_ff  <= req_corner_x;
         qy_ff  <= req_corner_y;
         amt_ff <= req_amount;
      end
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      prod_ff <= prod_in;
      fit_ff  <= fit_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      sts.div_done   = div_done;
      sts.short_path = 1'b0;
      if (cmd_ff == vcpz_pkg::CMD_ZOOM_AT) sts.short_path = (amt_ff == 24'd0);
      else if (cmd_ff == vcpz_pkg::CMD_FRAME) sts.short_path = degen || vp_zero;
   end

   assign rsp_out_x = ((cmd_ff == vcpz_pkg::CMD_W2S) || (cmd_ff == vcpz_pkg::CMD_S2W))
                      ? ox_ff : 32'sd0;
   assign rsp_out_y = ((cmd_ff == vcpz_pkg::CMD_W2S) || (cmd_ff == vcpz_pkg::CMD_S2W))
                      ? oy_ff : 32'sd0;
   assign rsp_center_x   = cx_ff;
   assign rsp_center_y   = cy_ff;
   assign rsp_zoom_level = zoom_ff;
   assign rsp_ignored    = ign_ff;

endmodule

### sv/vcpz_ctrl.sv
// ----------------------------------------------------------------------------
// vcpz_ctrl: command sequencer
// Steps through the micro-sequence of the accepted command, waits on the
// divider and raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module vcpz_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  vcpz_pkg::cmd_type    req_command,
   output logic                 busy,
   output logic                 rsp_valid,
   output vcpz_pkg::dp_cmd_type ctl,
   input  vcpz_pkg::dp_sts_type sts
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WAIT = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [vcpz_pkg::PC_W-1:0]   pc_ff, pc_in;
   vcpz_pkg::cmd_type           cmd_ff, cmd_in;
   vcpz_pkg::uop_type           uop;

   assign uop = vcpz_pkg::ucode(cmd_ff, pc_ff, sts.short_path);

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      cmd_in    = cmd_ff;
      ctl.load  = 1'b0;
      ctl.issue = 1'b0;
      ctl.op    = uop.op;
      ctl.axis  = uop.axis;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctl.load = 1'b1;
               cmd_in   = req_command;
               pc_in    = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.issue = 1'b1;
            if (vcpz_pkg::is_div_op(uop.op)) begin
               state_in = S_WAIT;
            end else if (uop.last) begin
               state_in = S_RESP;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         S_WAIT: begin
            if (sts.div_done) begin
               pc_in    = pc_ff + 1'b1;
               state_in = S_EXEC;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff    <= '0;
         cmd_ff   <= vcpz_pkg::CMD_W2S;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   ap_wait_has_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> vcpz_pkg::is_div_op(uop.op))
      else $error("waiting on divider without a divide step");
   ap_load_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (state_ff == S_EXEC) && (pc_ff == '0))
      else $error("accepted request did not start its sequence");
   ap_issue_excl: assert property (@(posedge clock) disable iff (reset)
      !(ctl.load && ctl.issue))
      else $error("load and issue together");

endmodule

### sv/view_camera_pan_zoom.sv
// ----------------------------------------------------------------------------
// view_camera_pan_zoom: 2D view camera with pan and zoom about a point
// Keeps a camera centre and zoom and executes one camera command per request.
// ----------------------------------------------------------------------------
// Usage. A request is accepted at a rising edge where start is high and busy is
// low; its command, point, corner and amount are sampled there. The block then
// works on that one request and raises busy until it is done. The result of
// every request appears on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; the receiver cannot stall, so it must take the result then.
// How long a request takes depends on the command, since every quotient goes
// through one shared serial divider: set_zoom, unknown commands, rejected
// zoom_at and a degenerate frame use no divide, nor does world_to_screen;
// screen_to_world, pan and frame with a real box use two divides, zoom_at four.
// Busy drops right after the result cycle, so the next request can be accepted
// in the cycle after the result cycle.
// Configuration registers are written through the csr_ port, which is always
// ready; they should be written only while the block is idle. Reset restores
// the 1280 by 720 viewport, the default zoom limits, a centre at the origin and
// a zoom of one; no request is in flight after reset.
// ----------------------------------------------------------------------------
module view_camera_pan_zoom #(
   parameter int COORD_FRAC_BITS = vcpz_pkg::COORD_FRAC_BITS_DEF,
   parameter int ZOOM_FRAC_BITS  = vcpz_pkg::ZOOM_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_command,
   input  logic signed [31:0]            req_point_x,
   input  logic signed [31:0]            req_point_y,
   input  logic signed [31:0]            req_corner_x,
   input  logic signed [31:0]            req_corner_y,
   input  logic [23:0]                   req_amount,
   output logic                          rsp_valid,
   output logic signed [31:0]            rsp_out_x,
   output logic signed [31:0]            rsp_out_y,
   output logic signed [31:0]            rsp_center_x,
   output logic signed [31:0]            rsp_center_y,
   output logic [23:0]                   rsp_zoom_level,
   output logic                          rsp_ignored,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vcpz_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vcpz_pkg::CSR_DAT_W-1:0] csr_data
);

   vcpz_pkg::dp_cmd_type ctl;
   vcpz_pkg::dp_sts_type sts;
   logic                 accept;

   // Configuration writes never wait.
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // The sequencer decides which datapath step runs in each cycle.
   vcpz_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .req_command (req_command),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .ctl         (ctl),
      .sts         (sts)
   );

   // The datapath holds all camera and configuration state.
   vcpz_dp #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .ZOOM_FRAC_BITS (ZOOM_FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .sts            (sts),
      .req_command    (req_command),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_corner_x   (req_corner_x),
      .req_corner_y   (req_corner_y),
      .req_amount     (req_amount),
      .csr_wr         (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_center_x   (rsp_center_x),
      .rsp_center_y   (rsp_center_y),
      .rsp_zoom_level (rsp_zoom_level),
      .rsp_ignored    (rsp_ignored)
   );

   ap_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a request");
   ap_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle");
   ap_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_valid)
      else $error("accepted request did not raise busy");
   ap_zoom_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zoom_level != 24'd0))
      else $error("zoom became zero");

endmodule
